>>> rtl/vapw_pkg.sv
// Shared types, register codes and helper functions for the virtual address page walk.
// Depends on nothing; every other file in rtl/ imports this package.
package vapw_pkg;

  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 27;
  localparam int unsigned DigitW     = 10;
  localparam int unsigned NumDigits  = 5;
  localparam int unsigned LevelW     = 3;
  localparam int unsigned BaseW      = 51;
  localparam int unsigned OffsetW    = 48;
  localparam int unsigned PageW      = 50;
  localparam int unsigned PMaskW     = 56;
  localparam int unsigned MinShift   = 13;
  localparam int unsigned MaxShift   = 48;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BOUND_1     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOUND_2     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOUND_3     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BOUND_4     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_SHIFT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ROOT_PAGE   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SPACE_NUM   = 3'd6;

  // Command and result kind codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_WORD   = 1'b1;
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] virtual_addr;
    logic [63:0] mem_word;
  } vapw_in_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] read_addr;
    logic [62:0] phys_addr;
    logic        privileged;
    logic        io_space;
    logic        out_of_bounds;
    logic        space_mismatch;
    logic        perm_read;
    logic        perm_write;
    logic        perm_exec;
  } vapw_out_t;

  typedef struct packed {
    logic [3:0]  bound_1;
    logic [3:0]  bound_2;
    logic [3:0]  bound_3;
    logic [3:0]  bound_4;
    logic [5:0]  page_shift;
    logic [26:0] root_page;
    logic [9:0]  space_number;
  } vapw_cfg_t;

  // Decoded view of a translation start
  typedef struct packed {
    logic                       direct;
    logic [62:0]                phys_addr;
    logic                       io_space;
    logic [NumDigits*DigitW-1:0] digits;
    logic [DigitW-1:0]          first_digit;
    logic [OffsetW-1:0]         offset;
    logic                       out_of_bounds;
    logic [LevelW-1:0]          level;
    logic [BaseW-1:0]           table_base;
  } vapw_start_t;

  // Clamp the page shift into its legal range
  function automatic logic [5:0] eff_shift(input logic [5:0] ps);
    logic [5:0] s;
    s = ps;
    if (s < 6'(MinShift)) s = 6'(MinShift);
    if (s > 6'(MaxShift)) s = 6'(MaxShift);
    return s;
  endfunction

  // Ones below bit s
  function automatic logic [PMaskW-1:0] page_mask(input logic [5:0] s);
    return ~({PMaskW{1'b1}} << s);
  endfunction

endpackage

>>> rtl/virtual_address_page_walk.sv
// Top level of the virtual address page walk: configuration registers and channel glue.
// Depends on vapw_pkg, vapw_start, vapw_walk and vapw_obuf.
//
//   channel   direction  handshake                    payload
//   in        sink       in_valid_i / in_stall_o      in_data_i   (vapw_in_t)
//   out       source     out_valid_o / out_stall_i    out_data_o  (vapw_out_t)
//   cfg       sink       cfg_we_i (always taken)      cfg_index_i, cfg_data_i
//
// Each input transfer is handled combinationally; any result is registered in the
// output register, or the skid stage while that register is held. One input transfer
// per cycle is sustained; in_stall_o rises only when the two-entry buffer is full.
// Reset (rst_ni low, asynchronous) idles the walk and loads the register defaults.
// A start during a walk and a table word with no walk pending produce no result.
module virtual_address_page_walk import vapw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vapw_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vapw_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  vapw_cfg_t   cfg_q;
  vapw_start_t start;
  vapw_out_t   res;
  logic        res_valid;
  logic        buf_full;
  logic        in_acc;

  // Configuration registers; writes take effect on the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bound_1      <= '0;
      cfg_q.bound_2      <= '0;
      cfg_q.bound_3      <= '0;
      cfg_q.bound_4      <= '0;
      cfg_q.page_shift   <= 6'(MinShift);
      cfg_q.root_page    <= '0;
      cfg_q.space_number <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BOUND_1:    cfg_q.bound_1      <= cfg_data_i[3:0];
        CFG_BOUND_2:    cfg_q.bound_2      <= cfg_data_i[3:0];
        CFG_BOUND_3:    cfg_q.bound_3      <= cfg_data_i[3:0];
        CFG_BOUND_4:    cfg_q.bound_4      <= cfg_data_i[3:0];
        CFG_PAGE_SHIFT: cfg_q.page_shift   <= cfg_data_i[5:0];
        CFG_ROOT_PAGE:  cfg_q.root_page    <= cfg_data_i[26:0];
        CFG_SPACE_NUM:  cfg_q.space_number <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Hold input only while the skid stage is occupied
  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !buf_full;

  vapw_start u_start (
    .virtual_addr_i (in_data_i.virtual_addr),
    .cfg_i          (cfg_q),
    .start_o        (start)
  );

  vapw_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .in_data_i   (in_data_i),
    .start_i     (start),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vapw_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> rtl/vapw_start.sv
// Start-side decode: direct mapping, page digits, segment bounds and first walk level.
// Depends on vapw_pkg; purely combinational.
module vapw_start import vapw_pkg::*; (
  input  logic [63:0] virtual_addr_i,
  input  vapw_cfg_t   cfg_i,
  output vapw_start_t start_o
);

  logic [5:0]         shift;
  logic [1:0]         seg;
  logic [60:0]        rel;
  logic [60:0]        page_full;
  logic [PageW-1:0]   page;
  logic [PMaskW-1:0]  omask;
  logic [3:0]         blo;
  logic [3:0]         bhi;
  logic [3:0]         span;
  logic [6:0]         above;
  logic [LevelW-1:0]  lvl;
  logic [DigitW-1:0]  dig [NumDigits];

  function automatic logic [3:0] bound_of(input vapw_cfg_t c, input logic [2:0] k);
    logic [3:0] b;
    case (k)
      3'd1:    b = c.bound_1;
      3'd2:    b = c.bound_2;
      3'd3:    b = c.bound_3;
      3'd4:    b = c.bound_4;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  always_comb begin
    shift     = eff_shift(cfg_i.page_shift);
    omask     = page_mask(shift);
    seg       = virtual_addr_i[62:61];
    rel       = virtual_addr_i[60:0];
    page_full = rel >> shift;
    page      = page_full[PageW-1:0];
    for (int i = 0; i < NumDigits; i++) begin
      dig[i] = page[i*DigitW +: DigitW];
    end
    // above[d]: page needs more than d digits
    for (int d = 0; d < 7; d++) begin
      above[d] = |(page_full >> (DigitW * d));
    end
    blo  = bound_of(cfg_i, {1'b0, seg});
    bhi  = bound_of(cfg_i, 3'({1'b0, seg}) + 3'd1);
    span = bhi - blo;
    lvl  = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (dig[i] != '0) lvl = LevelW'(i);
    end
  end

  always_comb begin
    start_o.direct        = virtual_addr_i[63];
    start_o.phys_addr     = virtual_addr_i[62:0];
    start_o.io_space      = |virtual_addr_i[62:48];
    start_o.digits        = page;
    start_o.first_digit   = dig[lvl];
    start_o.offset        = rel[OffsetW-1:0] & omask[OffsetW-1:0];
    start_o.level         = lvl;
    start_o.table_base    = BaseW'(cfg_i.root_page) + BaseW'(blo) + BaseW'(lvl);
    if (bhi < blo) begin
      start_o.out_of_bounds = 1'b1;
    end else if (span > 4'd6) begin
      start_o.out_of_bounds = 1'b0;
    end else begin
      start_o.out_of_bounds = above[span[2:0]];
    end
  end

endmodule

>>> rtl/vapw_walk.sv
// Walk state and per-transfer result logic: starts walks, consumes table words.
// Depends on vapw_pkg and the decode from vapw_start.
module vapw_walk import vapw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  vapw_in_t    in_data_i,
  input  vapw_start_t start_i,
  input  vapw_cfg_t   cfg_i,
  output logic        res_valid_o,
  output vapw_out_t   res_o
);

  logic               busy_q, busy_d;
  logic [LevelW-1:0]  level_q, level_d;
  logic [DigitW-1:0]  digits_q [NumDigits];
  logic [DigitW-1:0]  digits_d [NumDigits];
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [BaseW-1:0]   base_q, base_d;
  logic               bounds_q, bounds_d;
  logic               mism_q, mism_d;
  logic [63:0]        w;
  logic [PMaskW-1:0]  pbase;
  logic [56:0]        psum;

  always_comb begin
    busy_d      = busy_q;
    level_d     = level_q;
    digits_d    = digits_q;
    offset_d    = offset_q;
    base_d      = base_q;
    bounds_d    = bounds_q;
    mism_d      = mism_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    w           = in_data_i.mem_word;
    pbase       = {w[55:3], 3'd0} & ~page_mask(eff_shift(cfg_i.page_shift));
    psum        = 57'(pbase) + 57'(offset_q);
    if (acc_i) begin
      if (in_data_i.cmd == CMD_START) begin
        if (!busy_q) begin
          res_valid_o = 1'b1;
          if (start_i.direct) begin
            res_o.kind       = KIND_DONE;
            res_o.phys_addr  = start_i.phys_addr;
            res_o.privileged = 1'b1;
            res_o.io_space   = start_i.io_space;
          end else begin
            for (int i = 0; i < NumDigits; i++) begin
              digits_d[i] = start_i.digits[i*DigitW +: DigitW];
            end
            offset_d        = start_i.offset;
            bounds_d        = start_i.out_of_bounds;
            mism_d          = 1'b0;
            level_d         = start_i.level;
            base_d          = start_i.table_base;
            busy_d          = 1'b1;
            res_o.kind      = KIND_READ;
            res_o.read_addr = {start_i.table_base, start_i.first_digit, 3'd0};
          end
        end
      end else if (busy_q) begin
        res_valid_o = 1'b1;
        mism_d      = mism_q | (w[12:3] != cfg_i.space_number);
        if (level_q != '0) begin
          // Pointer to the next table down
          base_d          = {1'b0, w[62:13]};
          level_d         = level_q - LevelW'(1);
          res_o.kind      = KIND_READ;
          res_o.read_addr = {base_d, digits_q[level_d], 3'd0};
        end else begin
          busy_d               = 1'b0;
          res_o.kind           = KIND_DONE;
          res_o.phys_addr      = 63'(psum);
          res_o.out_of_bounds  = bounds_q;
          res_o.space_mismatch = mism_d;
          res_o.perm_read      = w[2];
          res_o.perm_write     = w[1];
          res_o.perm_exec      = w[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= '0;
    end else begin
      busy_q  <= busy_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    offset_q <= offset_d;
    base_q   <= base_d;
    bounds_q <= bounds_d;
    mism_q   <= mism_d;
  end

  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> level_q == '0)
    else $error("walk level nonzero while idle");

  a_word_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && in_data_i.cmd == CMD_WORD && busy_q) |-> res_valid_o)
    else $error("table word during a walk gave no result");

  a_pte_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && in_data_i.cmd == CMD_WORD && busy_q && level_q == '0) |=> !busy_q)
    else $error("walk still busy after the PTE");

endmodule

>>> rtl/vapw_obuf.sv
// Result register with a skid stage so input transfers continue while a result waits.
// Depends on vapw_pkg for the result type.
module vapw_obuf import vapw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  vapw_out_t push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  output vapw_out_t out_data_o,
  input  logic      out_stall_i
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  vapw_out_t out_data_q, out_data_d;
  vapw_out_t skid_data_q, skid_data_d;
  logic      pop;

  always_comb begin
    pop          = out_valid_q && !out_stall_i;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // Input is stalled; drain the skid stage on a transfer
      if (pop) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_d = push_i;
      out_data_d  = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result ahead of the output register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("result pushed while the skid stage is full");

endmodule

>>> tb/sv/vapw_translation_checker.sv
`timescale 1ns / 1ps
// Checker for virtual_address_page_walk: predicts every output transfer from the
// input and register traffic and compares it field by field. Depends on vapw_pkg.
module vapw_translation_checker import vapw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  vapw_in_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  vapw_out_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         error_count_o,
  output int unsigned         awaited_count_o,
  output int unsigned         checked_count_o
);

  localparam int unsigned PrintLimit = 40;

  vapw_cfg_t          regs;
  logic               walking;
  logic [LevelW-1:0]  fetch_level;
  logic [DigitW-1:0]  digit_q [NumDigits];
  logic [OffsetW-1:0] kept_offset;
  logic [BaseW-1:0]   next_table;
  logic               outside_bounds;
  logic               asn_wrong;
  vapw_out_t          awaited_results [$];

  task automatic report_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    error_count_o++;
    if (error_count_o <= PrintLimit)
      $display("%0t: page walk mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_error(what, got, want);
  endtask

  function automatic logic [5:0] clamped_shift();
    if (regs.page_shift < 6'(MinShift)) return 6'(MinShift);
    if (regs.page_shift > 6'(MaxShift)) return 6'(MaxShift);
    return regs.page_shift;
  endfunction

  // b0 is fixed at zero; segment k spans bound k to bound k+1
  function automatic logic [3:0] segment_limit(input logic [2:0] k);
    case (k)
      3'd1: return regs.bound_1;
      3'd2: return regs.bound_2;
      3'd3: return regs.bound_3;
      3'd4: return regs.bound_4;
      default: return 4'd0;
    endcase
  endfunction

  function automatic vapw_out_t table_read();
    vapw_out_t req;
    req = '0;
    req.kind = KIND_READ;
    req.read_addr = (64'(next_table) << 13) + (64'(digit_q[fetch_level]) << 3);
    return req;
  endfunction

  task automatic predict_walk_step(input vapw_in_t it);
    vapw_out_t   res;
    logic [5:0]  s;
    logic [1:0]  seg;
    logic [63:0] rel, page, pmask, pbase;
    logic [3:0]  lo, hi;
    int unsigned span;
    logic [2:0]  lvl;
    res = '0;
    if (it.cmd == CMD_START) begin
      if (walking) return;
      if (it.virtual_addr[63]) begin
        res.kind = KIND_DONE;
        res.phys_addr = it.virtual_addr[62:0];
        res.privileged = 1'b1;
        res.io_space = |it.virtual_addr[62:48];
        awaited_results.push_back(res);
        return;
      end
      s = clamped_shift();
      seg = it.virtual_addr[62:61];
      rel = {3'b000, it.virtual_addr[60:0]};
      page = rel >> s;
      pmask = (64'd1 << s) - 64'd1;
      kept_offset = OffsetW'(rel & pmask);
      for (int i = 0; i < NumDigits; i++) digit_q[i] = page[10*i +: 10];
      lo = segment_limit({1'b0, seg});
      hi = segment_limit({1'b0, seg} + 3'd1);
      if (hi < lo) begin
        outside_bounds = 1'b1;
      end else begin
        span = 10 * (int'(hi) - int'(lo));
        outside_bounds = (span < 64) && (page >= (64'd1 << span));
      end
      asn_wrong = 1'b0;
      lvl = '0;
      for (int i = 4; i >= 1; i--) if (lvl == '0 && digit_q[i] != '0) lvl = 3'(i);
      fetch_level = lvl;
      next_table = BaseW'(regs.root_page) + BaseW'(lo) + BaseW'(lvl);
      walking = 1'b1;
      awaited_results.push_back(table_read());
      return;
    end
    if (!walking) return;
    if (it.mem_word[12:3] != regs.space_number) asn_wrong = 1'b1;
    if (fetch_level != '0) begin
      next_table = BaseW'(it.mem_word[62:13]);
      fetch_level--;
      awaited_results.push_back(table_read());
    end else begin
      s = clamped_shift();
      pmask = (64'd1 << s) - 64'd1;
      pbase = it.mem_word & 64'h00FF_FFFF_FFFF_FFF8 & ~pmask;
      res.kind = KIND_DONE;
      res.phys_addr = 63'(pbase + 64'(kept_offset));
      res.out_of_bounds = outside_bounds;
      res.space_mismatch = asn_wrong;
      res.perm_read = it.mem_word[2];
      res.perm_write = it.mem_word[1];
      res.perm_exec = it.mem_word[0];
      walking = 1'b0;
      fetch_level = '0;
      awaited_results.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vapw_out_t want;
    if (!rst_ni) begin
      regs = '0;
      regs.page_shift = 6'(MinShift);
      walking = 1'b0;
      fetch_level = '0;
      for (int i = 0; i < NumDigits; i++) digit_q[i] = '0;
      kept_offset = '0;
      next_table = '0;
      outside_bounds = 1'b0;
      asn_wrong = 1'b0;
      awaited_results.delete();
      error_count_o = 0;
      checked_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BOUND_1:    regs.bound_1 = cfg_data_i[3:0];
          CFG_BOUND_2:    regs.bound_2 = cfg_data_i[3:0];
          CFG_BOUND_3:    regs.bound_3 = cfg_data_i[3:0];
          CFG_BOUND_4:    regs.bound_4 = cfg_data_i[3:0];
          CFG_PAGE_SHIFT: regs.page_shift = cfg_data_i[5:0];
          CFG_ROOT_PAGE:  regs.root_page = cfg_data_i[26:0];
          CFG_SPACE_NUM:  regs.space_number = cfg_data_i[9:0];
          default: ;
        endcase
      end
      // compare before predicting: a result never leaves in its own input's cycle
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_error("result with nothing awaited", out_data_i.read_addr,
                       64'(out_data_i.phys_addr));
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 64'(out_data_i.kind), 64'(want.kind));
          check_field("read_addr", out_data_i.read_addr, want.read_addr);
          check_field("phys_addr", 64'(out_data_i.phys_addr), 64'(want.phys_addr));
          check_field("privileged", 64'(out_data_i.privileged), 64'(want.privileged));
          check_field("io_space", 64'(out_data_i.io_space), 64'(want.io_space));
          check_field("out_of_bounds", 64'(out_data_i.out_of_bounds),
                      64'(want.out_of_bounds));
          check_field("space_mismatch", 64'(out_data_i.space_mismatch),
                      64'(want.space_mismatch));
          check_field("perm_read", 64'(out_data_i.perm_read), 64'(want.perm_read));
          check_field("perm_write", 64'(out_data_i.perm_write), 64'(want.perm_write));
          check_field("perm_exec", 64'(out_data_i.perm_exec), 64'(want.perm_exec));
          checked_count_o++;
        end
      end
      if (in_valid_i && !in_stall_i) predict_walk_step(in_data_i);
    end
    awaited_count_o = awaited_results.size();
  end

endmodule

>>> tb/sv/virtual_address_page_walk_tb.sv
`timescale 1ns / 1ps
// Top of the page walk testbench: clock, reset, register settings, walk stimulus and verdict.
// Depends on vapw_pkg, vapw_translation_checker and the virtual_address_page_walk RTL.
module virtual_address_page_walk_tb;
  import vapw_pkg::*;

  localparam int unsigned NumPhases     = 12;
  localparam int unsigned ItemsPerPhase = 90;
  localparam int unsigned HoldCycles    = 300;
  // settle time after every awaited result has been taken
  localparam int unsigned SettleCycles  = 4;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  vapw_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  vapw_out_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned error_count;
  int unsigned awaited_count;
  int unsigned checked_count;

  // traffic shaping, shared between the sender and the result sink
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 84;
  logic        hold_req = 1'b0;

  vapw_cfg_t   cur_cfg;
  int unsigned items_sent = 0;

  virtual_address_page_walk i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  vapw_translation_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .error_count_o   (error_count),
    .awaited_count_o (awaited_count),
    .checked_count_o (checked_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: fires far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result sink: random stalls per the current mode, plus one long hold-off on request
  // that lets the result buffer fill and push back on the input channel.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        for (int unsigned n = 0; n < HoldCycles; n++) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [63:0] random64();
    return {$urandom, $urandom};
  endfunction

  // Number of table words the current walk will ask for: one per level from the
  // highest nonzero page digit down to level 1, plus the PTE.
  function automatic int unsigned walk_words(input logic [63:0] va);
    logic [5:0]  s;
    logic [63:0] page;
    s = cur_cfg.page_shift;
    if (s < 6'(MinShift)) s = 6'(MinShift);
    if (s > 6'(MaxShift)) s = 6'(MaxShift);
    page = {3'b000, va[60:0]} >> s;
    for (int i = 4; i >= 1; i--) if (page[10*i +: 10] != '0) return i + 1;
    return 1;
  endfunction

  // Table word with random content; mostly carrying the right address-space number.
  function automatic logic [63:0] table_word();
    logic [63:0] w;
    w = random64();
    if ($urandom_range(99) < 85) w[12:3] = cur_cfg.space_number;
    return w;
  endfunction

  // Pick the traffic mode from progress: receiver-light first, then sender-light, then none.
  task automatic pick_idle_mode();
    if (items_sent < 340) begin
      send_idle_pct = 37;
      recv_idle_pct = 84;
    end else if (items_sent < 680) begin
      send_idle_pct = 84;
      recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Offer one item and hold it until the transfer completes. Valid stays high on
  // return so back-to-back items never drop it within one step.
  task automatic offer(input vapw_in_t it, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (counted) items_sent++;
  endtask

  task automatic send_start(input logic [63:0] va, input bit counted);
    vapw_in_t it;
    it.cmd = CMD_START;
    it.virtual_addr = va;
    it.mem_word = random64();
    offer(it, counted);
  endtask

  task automatic send_word(input logic [63:0] w, input bit counted);
    vapw_in_t it;
    it.cmd = CMD_WORD;
    it.virtual_addr = random64();
    it.mem_word = w;
    offer(it, counted);
  endtask

  // Drop valid and wait until every awaited result has been taken, then let the
  // block settle. Sample the count at the falling edge, clear of checker updates.
  task automatic settle_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (awaited_count != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic load_config(input vapw_cfg_t c);
    write_reg(CFG_BOUND_1, CfgDataW'(c.bound_1));
    write_reg(CFG_BOUND_2, CfgDataW'(c.bound_2));
    write_reg(CFG_BOUND_3, CfgDataW'(c.bound_3));
    write_reg(CFG_BOUND_4, CfgDataW'(c.bound_4));
    write_reg(CFG_PAGE_SHIFT, CfgDataW'(c.page_shift));
    write_reg(CFG_ROOT_PAGE, CfgDataW'(c.root_page));
    write_reg(CFG_SPACE_NUM, CfgDataW'(c.space_number));
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  // Register setting per phase: the first few pin extremes and out-of-range shifts,
  // the rest are random with a legal shift.
  function automatic vapw_cfg_t phase_setting(input int unsigned p);
    vapw_cfg_t c;
    c.bound_1      = 4'($urandom);
    c.bound_2      = 4'($urandom);
    c.bound_3      = 4'($urandom);
    c.bound_4      = 4'($urandom);
    c.page_shift   = 6'($urandom_range(MinShift, MaxShift));
    c.root_page    = 27'($urandom);
    c.space_number = 10'($urandom);
    case (p)
      0: begin
        // segment 1 empty (b2 < b1), segment 2 holds page 0 only, segment 3 unlimited
        c.bound_1 = 4'd3;
        c.bound_2 = 4'd1;
        c.bound_3 = 4'd1;
        c.bound_4 = 4'd15;
        c.page_shift = 6'(MinShift);
        c.root_page = '1;
        c.space_number = '1;
      end
      1: begin
        c = '0;
        c.page_shift = 6'(MinShift);
      end
      2: begin
        c = '1;
        c.page_shift = 6'(MaxShift);
      end
      3: c.page_shift = 6'd0;
      4: c.page_shift = 6'h3f;
      5: c.page_shift = 6'(MinShift - 1);
      6: c.page_shift = 6'(MaxShift + 1);
      default: ;
    endcase
    return c;
  endfunction

  // Short directed walk set under the phase 0 setting.
  task automatic run_directed();
    // direct-mapped: plain, all ones (I/O region), low 48 bits set outside I/O
    send_start(64'h8000_0000_0000_0000, 1'b1);
    send_start(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_start(64'h8000_FFFF_FFFF_FFFF, 1'b1);
    // table word with no walk pending: dropped
    send_word('1, 1'b0);
    // page 0 of segment 0: PTE only, all-ones word
    send_start('0, 1'b1);
    send_word('1, 1'b1);
    // deepest walk in the empty segment; a start inside it is dropped
    send_start(64'h3FFF_FFFF_FFFF_FFFF, 1'b1);
    send_start(64'h8000_0000_0000_0001, 1'b0);
    send_word('0, 1'b1);
    repeat (walk_words(64'h3FFF_FFFF_FFFF_FFFF) - 1) send_word(table_word(), 1'b1);
    // deepest walk in the unlimited segment
    send_start(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    repeat (walk_words(64'h7FFF_FFFF_FFFF_FFFF)) send_word(table_word(), 1'b1);
    // page 1 in a one-page segment: out of bounds, all-zero PTE
    send_start(64'h4000_0000_0000_2000, 1'b1);
    send_word('0, 1'b1);
  endtask

  // One translation with random content, sometimes wrapped in noise.
  task automatic random_walk();
    logic [63:0] va;
    int unsigned words;
    if ($urandom_range(99) < 4) send_word(random64(), 1'b0);
    va = random64();
    if ($urandom_range(99) < 15) begin
      va[63] = 1'b1;
      if ($urandom_range(1) == 0) va[62:48] = '0;
      send_start(va, 1'b1);
    end else begin
      // vary the magnitude so walks of every depth and both bounds outcomes show up
      va = {1'b0, va[62:61], 61'(random64() >> $urandom_range(3, 63))};
      words = walk_words(va);
      send_start(va, 1'b1);
      for (int unsigned n = 0; n < words; n++) begin
        if ($urandom_range(99) < 5) send_start(random64(), 1'b0);
        send_word(table_word(), 1'b1);
      end
    end
  endtask

  task automatic run_random(input int unsigned p);
    int unsigned target;
    bit          paused;
    target = items_sent + ItemsPerPhase;
    paused = 1'b0;
    if (p == 3) hold_req = 1'b1;
    while (items_sent < target) begin
      pick_idle_mode();
      random_walk();
      // once, stop offering mid-phase until the output side has caught up
      if (p == 6 && !paused && items_sent + ItemsPerPhase / 2 >= target) begin
        settle_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_BOUND_1;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers change only here, with the block idle and nothing awaited.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      load_config(phase_setting(p));
      if (p == 0) run_directed();
      else run_random(p);
      settle_results();
    end

    $display("Covered %0d input transfers under %0d register settings, with stalls on both sides.",
             items_sent, NumPhases);
    $display("Checked %0d output transfers: table reads, walk results and direct mappings.",
             checked_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
